@@ rtl/median3x3_filter_unit_defines.svh @@
// Assertion macros for the median filter unit.
`ifndef MEDIAN3X3_FILTER_UNIT_DEFINES_SVH
`define MEDIAN3X3_FILTER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define MF3_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("mf3 check failed");
`define MF3_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("mf3 check failed");
`else
`define MF3_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define MF3_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

@@ rtl/mf3_pkg.sv @@
package mf3_pkg;

  localparam int PIX_W          = 8;
  localparam int CFG_W          = 11;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int RESET_SIZE     = 512;
  localparam int MIN_SIZE       = 3;
  localparam int WIN_N          = 9;

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // window in column order: oldest column, previous column, newest column
  typedef struct packed {
    logic                   last;
    pix_t [WIN_N-1:0]       px;
  } win_item_t;

endpackage

@@ rtl/mf3_front.sv @@
module mf3_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int LIM_W      = 11
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  mf3_pkg::pix_t      in_pixel,
  output logic               in_stall,
  input  logic [LIM_W-1:0]   w_last,
  input  logic [LIM_W-1:0]   h_last,
  output logic               win_valid,
  input  logic               win_ready,
  output mf3_pkg::win_item_t win_item
);
  import mf3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int MW = 2 * PIX_W;

  // line store: upper byte is two rows above, lower byte one row above
  logic [MW-1:0] line_mem [MAX_WIDTH];
  logic [MW-1:0] mem_q_r;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          s1_v_r, s1_int_r, s1_last_r;
  pix_t          s1_px_r;
  logic [CW-1:0] s1_addr_r;
  pix_t          wnd_r [6];

  logic acc, s1_go, col_end, row_end;
  pix_t top, mid;

  assign top       = mem_q_r[MW-1:PIX_W];
  assign mid       = mem_q_r[PIX_W-1:0];
  assign s1_go     = s1_v_r && (!s1_int_r || win_ready);
  assign in_stall  = s1_v_r && !s1_go;
  assign acc       = in_valid && !in_stall;
  assign win_valid = s1_v_r && s1_int_r;

  assign col_end = LIM_W'(col_r) >= w_last;
  assign row_end = LIM_W'(row_r) >= h_last;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_comb begin
    win_item.last  = s1_last_r;
    win_item.px[0] = wnd_r[0];
    win_item.px[1] = wnd_r[1];
    win_item.px[2] = wnd_r[2];
    win_item.px[3] = wnd_r[3];
    win_item.px[4] = wnd_r[4];
    win_item.px[5] = wnd_r[5];
    win_item.px[6] = top;
    win_item.px[7] = mid;
    win_item.px[8] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      mem_q_r <= line_mem[col_r];
    end
    if (s1_go) begin
      line_mem[s1_addr_r] <= {mid, s1_px_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        wnd_r[i] <= '0;
      end
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go) begin
        wnd_r[0] <= wnd_r[3];
        wnd_r[1] <= wnd_r[4];
        wnd_r[2] <= wnd_r[5];
        wnd_r[3] <= top;
        wnd_r[4] <= mid;
        wnd_r[5] <= s1_px_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_px_r   <= in_pixel;
      s1_addr_r <= col_r;
      s1_int_r  <= (row_r >= RW'(2)) && (col_r >= CW'(2));
      s1_last_r <= (LIM_W'(row_r) == h_last) && (LIM_W'(col_r) == w_last);
    end
  end

endmodule

@@ rtl/mf3_sort.sv @@
module mf3_sort (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               win_valid,
  output logic               win_ready,
  input  mf3_pkg::win_item_t win_item,
  output logic               out_valid,
  input  logic               out_stall,
  output mf3_pkg::pix_t      out_median,
  output logic               out_frame_last
);
  import mf3_pkg::*;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // column sort stage
  logic vc_r, lc_r;
  pix_t lo_r [3];
  pix_t md_r [3];
  pix_t hi_r [3];
  // max of lows, median of middles, min of highs
  logic vm_r, lm_r;
  pix_t a_r, b_r, c_r;
  // output register
  logic vo_r, lo_last_r;
  pix_t med_r;

  logic rdy_c, rdy_m, rdy_o;

  assign rdy_o     = !vo_r || !out_stall;
  assign rdy_m     = !vm_r || rdy_o;
  assign rdy_c     = !vc_r || rdy_m;
  assign win_ready = rdy_c;

  assign out_valid      = vo_r;
  assign out_median     = med_r;
  assign out_frame_last = lo_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vm_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy_c) begin
        vc_r <= win_valid;
      end
      if (rdy_m) begin
        vm_r <= vc_r;
      end
      if (rdy_o) begin
        vo_r <= vm_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && win_valid) begin
      lc_r <= win_item.last;
      for (int k = 0; k < 3; k++) begin
        lo_r[k] <= min2(min2(win_item.px[3*k], win_item.px[3*k+1]), win_item.px[3*k+2]);
        md_r[k] <= med3(win_item.px[3*k], win_item.px[3*k+1], win_item.px[3*k+2]);
        hi_r[k] <= max2(max2(win_item.px[3*k], win_item.px[3*k+1]), win_item.px[3*k+2]);
      end
    end
    if (rdy_m && vc_r) begin
      lm_r <= lc_r;
      a_r  <= max2(max2(lo_r[0], lo_r[1]), lo_r[2]);
      b_r  <= med3(md_r[0], md_r[1], md_r[2]);
      c_r  <= min2(min2(hi_r[0], hi_r[1]), hi_r[2]);
    end
    if (rdy_o && vm_r) begin
      lo_last_r <= lm_r;
      med_r     <= med3(a_r, b_r, c_r);
    end
  end

endmodule

@@ rtl/median3x3_filter_unit.sv @@
// 3x3 median filter for 8-bit grayscale frames in raster order.
// Input channel in_valid/in_stall/in_pixel takes one pixel per transfer;
// the output channel out_valid/out_stall carries out_median and
// out_frame_last, set on the result of the last interior pixel of a frame.
// Border rows and columns give no result, so a WxH frame gives (W-2)(H-2).
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes image_width
// (index 0) and image_height (index 1); values clamp to 3..MAX. cfg_ready is
// always high; write only while the pipeline is empty.
// Throughput: one pixel per clock while in_stall is low. The single line
// store (two rows packed in one word) is read when a pixel is taken and
// written back when that pixel leaves the first stage. A result passes
// the first stage, column sort, merge and final median registers; the line
// store read happens on the transfer edge itself.
// Reset (rst_n low, synchronous) clears the counters, window and pipeline,
// and sets both sizes to 512. Line store contents are left as they are.
// A stalled receiver holds the output register; the pipeline fills and then
// in_stall rises. Non-interior pixels keep flowing while the sorter is full.
`include "median3x3_filter_unit_defines.svh"

module median3x3_filter_unit #(
  parameter int MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mf3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  mf3_pkg::pix_t                in_pixel,
  output logic                         out_valid,
  input  logic                         out_stall,
  output mf3_pkg::pix_t                out_median,
  output logic                         out_frame_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  mf3_pkg::cfg_reg_t            cfg_index,
  input  logic [mf3_pkg::CFG_W-1:0]    cfg_data
);
  import mf3_pkg::*;

  localparam int LW_W  = $clog2(MAX_WIDTH + 1);
  localparam int LW_H  = $clog2(MAX_HEIGHT + 1);
  localparam int LW_WH = (LW_W > LW_H) ? LW_W : LW_H;
  localparam int LIM_W = (LW_WH > CFG_W) ? LW_WH : CFG_W;

  function automatic logic [LIM_W-1:0] size_last(input logic [CFG_W-1:0] v,
                                                 input logic [LIM_W-1:0] maxv);
    logic [LIM_W-1:0] ext;
    logic [LIM_W-1:0] sz;
    ext = LIM_W'(v);
    if (ext < LIM_W'(MIN_SIZE)) begin
      sz = LIM_W'(MIN_SIZE);
    end else if (ext > maxv) begin
      sz = maxv;
    end else begin
      sz = ext;
    end
    return sz - 1'b1;
  endfunction

  logic [CFG_W-1:0] width_r, height_r;
  logic [LIM_W-1:0] w_last, h_last;
  logic             win_valid, win_ready;
  win_item_t        win_item;

  assign cfg_ready = 1'b1;
  assign w_last    = size_last(width_r, LIM_W'(MAX_WIDTH));
  assign h_last    = size_last(height_r, LIM_W'(MAX_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(RESET_SIZE);
      height_r <= CFG_W'(RESET_SIZE);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_data;
        REG_IMAGE_HEIGHT: height_r <= cfg_data;
      endcase
    end
  end

  mf3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .LIM_W      (LIM_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_pixel  (in_pixel),
    .in_stall  (in_stall),
    .w_last    (w_last),
    .h_last    (h_last),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win_item  (win_item)
  );

  mf3_sort u_sort (
    .clk            (clk),
    .rst_n          (rst_n),
    .win_valid      (win_valid),
    .win_ready      (win_ready),
    .win_item       (win_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_median     (out_median),
    .out_frame_last (out_frame_last)
  );

  `MF3_ASSERT_IMP(a_stall_from_sorter, clk, rst_n, in_stall, win_valid && !win_ready)
  `MF3_ASSERT_IMP(a_sorter_full, clk, rst_n, !win_ready, out_valid && out_stall)
  `MF3_ASSERT_NXT(a_full_holds_out, clk, rst_n, !win_ready, out_valid)

endmodule

@@ verif/median3x3_filter_unit_test.sv @@
module median3x3_filter_unit_test;

  import mf3_pkg::*;

  localparam int MAX_COLS       = DEF_MAX_WIDTH;
  localparam int MAX_ROWS       = DEF_MAX_HEIGHT;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_PIXELS  = 600;
  localparam int REPORT_LIMIT   = 100;

  typedef struct packed {
    pix_t median;
    logic frame_last;
  } median_result_t;

  typedef enum int {
    PIX_UNIFORM,
    PIX_NARROW,
    PIX_EXTREME,
    PIX_FLAT
  } pix_style_t;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  pix_t                 in_pixel       = '0;
  logic                 out_valid;
  logic                 out_stall      = 1'b0;
  pix_t                 out_median;
  logic                 out_frame_last;
  logic                 cfg_valid      = 1'b0;
  logic                 cfg_ready;
  cfg_reg_t             cfg_index      = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]     cfg_data       = '0;

  // frame scan state
  logic [CFG_W-1:0]     width_reg      = CFG_W'(RESET_SIZE);
  logic [CFG_W-1:0]     height_reg     = CFG_W'(RESET_SIZE);
  pix_t                 row_above [MAX_COLS];
  pix_t                 row_above2 [MAX_COLS];
  pix_t                 win_cols [6]   = '{default: '0};
  int                   scan_col       = 0;
  int                   scan_row       = 0;

  median_result_t       pending_medians[$];
  int                   mismatch_count = 0;
  int                   pixels_sent    = 0;

  pix_style_t           pixel_style    = PIX_UNIFORM;
  int                   pixel_base     = 0;
  bit                   sender_steady  = 1'b0;
  int                   burst_left     = 0;

  logic [15:0]          stall_pattern  = '0;
  int                   stall_hold     = 0;

  median3x3_filter_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_median     (out_median),
    .out_frame_last (out_frame_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int effective_size(logic [CFG_W-1:0] v, int limit);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > limit) return limit;
    return int'(v);
  endfunction

  // value with at most four smaller and at least five not larger
  function automatic pix_t mid_of_nine(pix_t v[9]);
    int lt, le;
    for (int i = 0; i < 9; i++) begin
      lt = 0;
      le = 0;
      for (int j = 0; j < 9; j++) begin
        if (v[j] < v[i]) lt++;
        if (v[j] <= v[i]) le++;
      end
      if (lt <= 4 && le >= 5) return v[i];
    end
    return v[0];
  endfunction

  task automatic advance_scan(input pix_t px);
    int w, h, idx;
    pix_t up2, up1;
    pix_t nbr[9];
    median_result_t res;
    w = effective_size(width_reg, MAX_COLS);
    h = effective_size(height_reg, MAX_ROWS);
    idx = scan_col % MAX_COLS;
    up2 = row_above2[idx];
    up1 = row_above[idx];
    if (scan_row >= 2 && scan_col >= 2) begin
      nbr = '{win_cols[0], win_cols[1], win_cols[2], win_cols[3], win_cols[4],
              win_cols[5], up2, up1, px};
      res.median = mid_of_nine(nbr);
      res.frame_last = (scan_row == h - 1) && (scan_col == w - 1);
      pending_medians.push_back(res);
    end
    win_cols[0] = win_cols[3];
    win_cols[1] = win_cols[4];
    win_cols[2] = win_cols[5];
    win_cols[3] = up2;
    win_cols[4] = up1;
    win_cols[5] = px;
    row_above2[idx] = up1;
    row_above[idx] = px;
    if (scan_col >= w - 1) begin
      scan_col = 0;
      scan_row = (scan_row >= h - 1) ? 0 : scan_row + 1;
    end else begin
      scan_col++;
    end
  endtask

  function automatic pix_t draw_pixel();
    int v;
    case (pixel_style)
      PIX_NARROW: begin
        v = pixel_base + $urandom_range(6) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return pix_t'(v);
      end
      PIX_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
      PIX_FLAT: return pix_t'(pixel_base);
      default: return pix_t'($urandom_range(255));
    endcase
  endfunction

  task automatic push_pixel(input pix_t px);
    in_valid <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (in_stall);
    advance_scan(px);
    pixels_sent++;
  endtask

  task automatic send_pixel(input pix_t px);
    push_pixel(px);
    if (!sender_steady) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(5, 1)) @(posedge clk);
        burst_left = $urandom_range(12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_medians.size() != 0);
  endtask

  // empty pipeline before a register write or the end
  task automatic wait_idle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    width_reg = w;
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data <= h;
    do @(posedge clk); while (!cfg_ready);
    height_reg = h;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixels(input int n);
    repeat (n) send_pixel(draw_pixel());
  endtask

  // runs until the scan wraps to the start of a frame
  task automatic send_frame(input int pause_at);
    int count;
    count = 0;
    do begin
      send_pixel(draw_pixel());
      count++;
      if (count == pause_at) drain_results();
    end while (scan_col != 0 || scan_row != 0);
  endtask

  task automatic test_reset_sizes();
    pixel_style = PIX_UNIFORM;
    send_pixels(2 * RESET_SIZE + 40);
  endtask

  task automatic test_mid_frame_resize();
    wait_idle();
    set_frame_size(11'd20, 11'd3);
    send_frame(-1);
    send_frame(-1);
    wait_idle();
    set_frame_size(11'd6, 11'd3);
    pixel_style = PIX_NARROW;
    pixel_base = 128;
    send_pixels(15);
    wait_idle();
    set_frame_size(11'd6, 11'd5);
    send_frame(-1);
  endtask

  task automatic test_smallest_frames();
    wait_idle();
    set_frame_size(11'd0, 11'd2);
    pixel_style = PIX_FLAT;
    pixel_base = 0;
    send_frame(-1);
    wait_idle();
    set_frame_size(11'd3, 11'd1);
    pixel_base = 255;
    send_frame(-1);
    wait_idle();
    set_frame_size(11'd2, 11'd3);
    pixel_style = PIX_EXTREME;
    send_frame(-1);
    send_frame(-1);
    wait_idle();
    set_frame_size(11'd3, 11'd3);
    pixel_style = PIX_UNIFORM;
    repeat (3) send_frame(-1);
  endtask

  // oversized frame, first row only; the next size write shrinks it mid-frame
  task automatic test_largest_frames();
    wait_idle();
    set_frame_size(11'd2047, 11'd2047);
    pixel_style = PIX_UNIFORM;
    sender_steady = 1'b1;
    send_pixels(40);
    sender_steady = 1'b0;
  endtask

  task automatic test_random_frames();
    int start, pause_at;
    bit first;
    logic [CFG_W-1:0] wv, hv;
    start = pixels_sent;
    first = 1'b1;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      if (first || $urandom_range(9) < 7) begin
        case ($urandom_range(19))
          0: wv = CFG_W'($urandom_range(2));
          1, 2, 3, 4, 5: wv = CFG_W'($urandom_range(40, 11));
          default: wv = CFG_W'($urandom_range(10, 3));
        endcase
        case ($urandom_range(19))
          0: hv = CFG_W'($urandom_range(2));
          1, 2, 3: hv = CFG_W'($urandom_range(12, 8));
          default: hv = CFG_W'($urandom_range(7, 3));
        endcase
        wait_idle();
        set_frame_size(wv, hv);
        first = 1'b0;
      end
      pixel_style = ($urandom_range(2) == 0) ? pix_style_t'($urandom_range(3)) : PIX_UNIFORM;
      pixel_base = $urandom_range(255);
      sender_steady = ($urandom_range(4) == 0);
      pause_at = ($urandom_range(5) == 0) ? $urandom_range(8, 1) : -1;
      send_frame(pause_at);
    end
    sender_steady = 1'b0;
  endtask

  // receiver stall pattern, rotating; each new pattern has at least one bit clear
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_hold == 0) begin
        stall_hold = $urandom_range(300, 20);
        case ($urandom_range(3))
          0: stall_pattern = '0;
          1: stall_pattern = 16'($urandom & $urandom);
          2: stall_pattern = 16'($urandom);
          default: stall_pattern = 16'($urandom | $urandom);
        endcase
        stall_pattern = stall_pattern & ~(16'h1 << $urandom_range(15));
      end else begin
        stall_hold--;
      end
      stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
      out_stall <= stall_pattern[0];
    end
  end

  always @(posedge clk) begin : check_results
    median_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_medians.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT)
          $display("%0t: unexpected transfer, expected none, actual median %0d last %0b",
                   $time, out_median, out_frame_last);
        mismatch_count++;
      end else begin
        want = pending_medians.pop_front();
        if (want.median !== out_median) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("%0t: median expected %0d actual %0d", $time, want.median, out_median);
          mismatch_count++;
        end
        if (want.frame_last !== out_frame_last) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("%0t: frame_last expected %0b actual %0b",
                     $time, want.frame_last, out_frame_last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_sizes();
    test_mid_frame_resize();
    test_smallest_frames();
    test_largest_frames();
    test_random_frames();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/mf3_pkg.sv
rtl/mf3_front.sv
rtl/mf3_sort.sv
rtl/median3x3_filter_unit.sv
verif/median3x3_filter_unit_test.sv
